@@ rtl/sbma_pkg.sv @@
`default_nettype none
package sbma_pkg;

    localparam int NUM_CLASSES   = 16;
    localparam int CLS_W         = 4;
    localparam int MAP_WORDS     = 128;
    localparam int IDX_W         = 7;
    localparam int WORD_BITS     = 32;
    localparam int BIT_W         = 5;
    localparam int BLK_W         = 11;
    localparam int SPAN_W        = 15;
    localparam int OFF_W         = 20;
    localparam int WRD_W         = 6;
    localparam int MAX_B256      = 64;
    localparam int MAX_REQ       = 256;
    localparam int DEFAULT_ALIGN = 4;

    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_BLOCKS = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NOT_SLOT = 2'd2,
        ST_NOT_USED = 2'd3
    } status_t;

    // floor(65536 / (c + 1))
    localparam logic [16:0] RECIP [NUM_CLASSES] = '{
        17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922,
        17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,
        17'd5041,  17'd4681,  17'd4369,  17'd4096
    };

    typedef struct packed {
        logic [31:0]       start;
        logic [BLK_W-1:0]  blocks;
        logic [IDX_W-1:0]  first;
        logic [WRD_W-1:0]  words;
        logic [SPAN_W-1:0] span;
    } cls_info_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_START,
        L_WAIT,
        L_WRITE
    } lay_state_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_A_CLS,
        E_A_RD,
        E_A_CHK,
        E_A_BIT,
        E_A_ADDR,
        E_F_CLS,
        E_F_DIV,
        E_F_RD,
        E_F_CHK,
        E_DONE
    } eng_state_t;

endpackage
`default_nettype wire

@@ rtl/size_class_bitmap_allocator_unit.sv @@
// Small-block allocator with 16 size classes of 16..256 bytes and one used-bit map.
// Input item on s_*: allocate, free or clear. One result item on m_* per input item:
// the allocated address (zero unless an allocate succeeds) and a status code.
// Configuration (cfg_*): index 0 base address, index 1 blocks_256; a write rebuilds
// the class layout (s_tready low meanwhile) and empties all maps.
// After reset the layout is built the same way before the first item is taken.
// Steps per item:
//   clear / unused op: no map read or write.
//   free: find the class whose span holds the address, divide, read and write back.
//   allocate, default alignment: try classes from the request's upward, word by word.
//   allocate, other alignment: as above, testing each non-full word one candidate bit per
//   cycle against the alignment.
// The map lives in one 128 x 32 RAM with registered read; each step is a read, a
// check and a write back, one item at a time.
// A result waits in the output register while m_tready is low; the next item is
// taken once the current one has finished, and its result holds until the output
// register is free.
`default_nettype none
module size_class_bitmap_allocator_unit
    import sbma_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] operation, [10:2] request_size, [14:11] align_log2, [46:15] free_address
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] result_address, [33:32] status
    output logic      [39:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic             layout_busy;
    logic [CLS_W-1:0] cls_sel;
    cls_info_t        cls_info;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;
    logic [31:0]      out_addr;
    logic [1:0]       out_status;

    sbma_layout u_layout (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rd_cls    (cls_sel),
        .rd_info   (cls_info),
        .busy      (layout_busy)
    );

    sbma_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sbma_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tdata[1:0]),
        .in_req      (s_tdata[10:2]),
        .in_align    (s_tdata[14:11]),
        .in_faddr    (s_tdata[46:15]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_addr    (out_addr),
        .out_status  (out_status),
        .layout_busy (layout_busy),
        .cfg_clear   (cfg_wr_en),
        .cls_sel     (cls_sel),
        .info        (cls_info),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    assign m_tdata = {6'd0, out_status, out_addr};

    a_cfg_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> layout_busy && !s_tready)
        else $error("layout not rebuilding after config write");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("failed item carries an address");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !layout_busy)
        else $error("map written during layout build");

endmodule
`default_nettype wire

@@ rtl/sbma_ram.sv @@
`default_nettype none
module sbma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/sbma_div.sv @@
`default_nettype none
module sbma_div
    import sbma_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [BLK_W-1:0] x,
    input  wire logic [CLS_W-1:0] cls,
    output logic                  done,
    output logic      [BLK_W-1:0] quot,
    output logic      [BIT_W-1:0] rem
);

    logic [27:0]      prod_reg;
    logic [BLK_W-1:0] x_reg;
    logic [CLS_W-1:0] cls_reg;
    logic             vld_reg;

    logic [4:0]       d;
    logic [BLK_W-1:0] q0;
    logic [15:0]      qd;
    logic [BLK_W-1:0] r0;
    logic             ge;
    logic [BLK_W-1:0] r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= start;
        end
        prod_reg <= {17'd0, x} * {11'd0, RECIP[cls]};
        x_reg    <= x;
        cls_reg  <= cls;
    end

    always_comb begin
        d    = {1'b0, cls_reg} + 5'd1;
        q0   = prod_reg[26:16];
        qd   = {5'd0, q0} * {11'd0, d};
        r0   = x_reg - qd[BLK_W-1:0];
        ge   = (r0 >= {6'd0, d});
        r1   = ge ? (r0 - {6'd0, d}) : r0;
        quot = q0 + {10'd0, ge};
        rem  = r1[BIT_W-1:0];
        done = vld_reg;
    end

endmodule
`default_nettype wire

@@ rtl/sbma_layout.sv @@
`default_nettype none
module sbma_layout
    import sbma_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [31:0]      cfg_wdata,
    input  wire logic [CLS_W-1:0] rd_cls,
    output cls_info_t             rd_info,
    output logic                  busy
);

    lay_state_t       state_reg, state_next;
    logic [31:0]      base_reg;
    logic [6:0]       b256_reg;
    logic [CLS_W-1:0] c_reg;
    logic [OFF_W-1:0] off_reg;
    logic [IDX_W-1:0] first_reg;
    logic [BLK_W-1:0] blk_reg;

    logic [31:0]       start_tab [NUM_CLASSES];
    logic [BLK_W-1:0]  blk_tab   [NUM_CLASSES];
    logic [IDX_W-1:0]  first_tab [NUM_CLASSES];
    logic [WRD_W-1:0]  words_tab [NUM_CLASSES];
    logic [SPAN_W-1:0] span_tab  [NUM_CLASSES];

    logic             div_start, div_done;
    logic [BLK_W-1:0] div_q;
    logic [BIT_W-1:0] div_rem;
    logic [6:0]       bclamp;
    logic [BLK_W-1:0] div_x;
    logic             tab_we;
    logic [WRD_W-1:0] words;
    logic [11:0]      wsum;
    logic [15:0]      units;
    logic [SPAN_W-1:0] span;
    logic [OFF_W-1:0] osum;
    logic [OFF_W-1:0] off_next;

    always_comb begin
        if (b256_reg == 7'd0) begin
            bclamp = 7'd1;
        end else if (b256_reg > 7'(MAX_B256)) begin
            bclamp = 7'(MAX_B256);
        end else begin
            bclamp = b256_reg;
        end
        div_x    = {bclamp, 4'd0};
        wsum     = {1'b0, blk_reg} + 12'd31;
        words    = wsum[10:5];
        units    = {5'd0, blk_reg} * {11'd0, ({1'b0, c_reg} + 5'd1)};
        span     = {units[10:0], 4'd0};
        osum     = off_reg + {5'd0, span} + {12'd0, words, 2'd0} + OFF_W'(31);
        off_next = {osum[OFF_W-1:5], 5'd0};
    end

    sbma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .x       (div_x),
        .cls     (c_reg),
        .done    (div_done),
        .quot    (div_q),
        .rem     (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:  state_next = L_IDLE;
            L_START: state_next = L_WAIT;
            L_WAIT:  if (div_done) state_next = L_WRITE;
            L_WRITE: state_next = (c_reg == CLS_W'(NUM_CLASSES - 1)) ? L_IDLE : L_START;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb begin
        div_start = (state_reg == L_START);
        tab_we    = (state_reg == L_WRITE);
        busy      = (state_reg != L_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_START;
            base_reg  <= 32'd0;
            b256_reg  <= 7'd16;
            c_reg     <= '0;
            off_reg   <= '0;
            first_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_BASE) begin
                base_reg <= cfg_wdata;
            end else begin
                b256_reg <= cfg_wdata[6:0];
            end
            state_reg <= L_START;
            c_reg     <= '0;
            off_reg   <= '0;
            first_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (tab_we) begin
                c_reg     <= c_reg + CLS_W'(1);
                off_reg   <= off_next;
                first_reg <= first_reg + IDX_W'(words);
            end
        end
        if (state_reg == L_WAIT && div_done) begin
            blk_reg <= div_q;
        end
        if (tab_we) begin
            start_tab[c_reg] <= base_reg + {{(32-OFF_W){1'b0}}, off_reg};
            blk_tab[c_reg]   <= blk_reg;
            first_tab[c_reg] <= first_reg;
            words_tab[c_reg] <= words;
            span_tab[c_reg]  <= span;
        end
    end

    always_comb begin
        rd_info.start  = start_tab[rd_cls];
        rd_info.blocks = blk_tab[rd_cls];
        rd_info.first  = first_tab[rd_cls];
        rd_info.words  = words_tab[rd_cls];
        rd_info.span   = span_tab[rd_cls];
    end

endmodule
`default_nettype wire

@@ rtl/sbma_engine.sv @@
`default_nettype none
module sbma_engine
    import sbma_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_op,
    input  wire logic [8:0]       in_req,
    input  wire logic [3:0]       in_align,
    input  wire logic [31:0]      in_faddr,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [31:0]      out_addr,
    output logic      [1:0]       out_status,
    input  wire logic             layout_busy,
    input  wire logic             cfg_clear,
    output logic      [CLS_W-1:0] cls_sel,
    input  cls_info_t             info,
    output logic                  ram_we,
    output logic      [IDX_W-1:0] ram_waddr,
    output logic      [31:0]      ram_wdata,
    output logic      [IDX_W-1:0] ram_raddr,
    input  wire logic [31:0]      ram_rdata
);

    eng_state_t       state_reg, state_next;
    logic [3:0]       align_reg;
    logic [31:0]      faddr_reg;
    logic [CLS_W-1:0] c_reg;
    logic [BIT_W-1:0] w_reg;
    logic [BIT_W-1:0] j_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      word_reg;
    logic [31:0]      free_reg;
    logic [31:0]      a_reg;
    logic [31:0]      res_addr_reg;
    logic [1:0]       res_status_reg;
    logic             m_valid_reg;
    logic [31:0]      m_addr_reg;
    logic [1:0]       m_status_reg;
    logic [MAP_WORDS-1:0] vld_reg;
    logic             vq_reg;

    logic             accept;
    logic [4:0]       d5;
    logic [8:0]       size9;
    logic [31:0]      rd_word;
    logic [BLK_W-1:0] left;
    logic [31:0]      vmask;
    logic [31:0]      used;
    logic             full;
    logic [31:0]      free_bits;
    logic [BIT_W-1:0] low_bit;
    logic [BIT_W-1:0] ap_bit;
    logic [14:0]      aprod;
    logic [31:0]      addr_calc;
    logic [15:0]      amask;
    logic             aligned;
    logic [31:0]      foff;
    logic             in_span;
    logic             last_word, last_cls, default_al, too_big;
    logic [IDX_W-1:0] word_idx;
    logic [CLS_W-1:0] req_cls;
    logic [8:0]       req_m1;
    logic             div_start, div_done;
    logic [BLK_W-1:0] div_q;
    logic [BIT_W-1:0] div_rem;
    logic             found;

    always_comb begin
        accept     = in_valid && in_ready;
        d5         = {1'b0, c_reg} + 5'd1;
        size9      = {d5, 4'd0};
        rd_word    = vq_reg ? ram_rdata : 32'd0;
        left       = info.blocks - {1'b0, w_reg, 5'd0};
        vmask      = (left[10:5] != 6'd0) ? 32'hFFFF_FFFF : ((32'd1 << left[4:0]) - 32'd1);
        used       = rd_word & vmask;
        full       = (used == vmask);
        free_bits  = ~used & vmask;
        low_bit    = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) low_bit = BIT_W'(j);
        end
        ap_bit     = (state_reg == E_A_CHK) ? BIT_W'(WORD_BITS - 1) : j_reg;
        aprod      = {10'd0, d5} * {5'd0, w_reg, ap_bit};
        addr_calc  = info.start + {13'd0, aprod, 4'd0};
        amask      = (16'd1 << align_reg) - 16'd1;
        aligned    = ((a_reg[15:0] & amask) == 16'd0);
        foff       = faddr_reg - info.start;
        in_span    = (foff < {17'd0, info.span});
        last_word  = (w_reg == '0);
        last_cls   = (c_reg == CLS_W'(NUM_CLASSES - 1));
        default_al = (align_reg == 4'(DEFAULT_ALIGN));
        too_big    = (in_req > 9'(MAX_REQ));
        req_m1     = in_req - 9'd1;
        req_cls    = (in_req == 9'd0) ? '0 : req_m1[7:4];
        word_idx   = info.first + {2'd0, w_reg};
        found      = free_reg[j_reg] && aligned;
        cls_sel    = c_reg;
    end

    sbma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .x       (foff[14:4]),
        .cls     (c_reg),
        .done    (div_done),
        .quot    (div_q),
        .rem     (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_ALLOC: state_next = too_big ? E_DONE : E_A_CLS;
                        OP_FREE:  state_next = E_F_CLS;
                        default:  state_next = E_DONE;
                    endcase
                end
            end
            E_A_CLS: begin
                if (info.words != '0) state_next = E_A_RD;
                else if (last_cls) state_next = E_DONE;
            end
            E_A_RD: state_next = E_A_CHK;
            E_A_CHK: begin
                if (full) begin
                    if (!last_word) state_next = E_A_RD;
                    else state_next = last_cls ? E_DONE : E_A_CLS;
                end else begin
                    state_next = default_al ? E_A_ADDR : E_A_BIT;
                end
            end
            E_A_BIT: begin
                if (found) state_next = E_DONE;
                else if (j_reg == '0) begin
                    if (!last_word) state_next = E_A_RD;
                    else state_next = last_cls ? E_DONE : E_A_CLS;
                end
            end
            E_A_ADDR: state_next = E_DONE;
            E_F_CLS: begin
                if (in_span) state_next = (foff[3:0] != 4'd0) ? E_DONE : E_F_DIV;
                else if (last_cls) state_next = E_DONE;
            end
            E_F_DIV: if (div_done) state_next = (div_rem != '0) ? E_DONE : E_F_RD;
            E_F_RD:  state_next = E_F_CHK;
            E_F_CHK: state_next = E_DONE;
            E_DONE:  if (!m_valid_reg || out_ready) state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == E_IDLE) && !layout_busy;
        div_start = (state_reg == E_F_CLS) && in_span && (foff[3:0] == 4'd0);
        ram_raddr = (state_reg == E_F_RD) ? idx_reg : word_idx;
        ram_we    = 1'b0;
        ram_waddr = word_idx;
        ram_wdata = rd_word | (32'd1 << low_bit);
        unique case (state_reg)
            E_A_CHK: ram_we = !full && default_al;
            E_A_BIT: begin
                ram_we    = found;
                ram_wdata = word_reg | (32'd1 << j_reg);
            end
            E_F_CHK: begin
                ram_we    = rd_word[j_reg];
                ram_waddr = idx_reg;
                ram_wdata = rd_word & ~(32'd1 << j_reg);
            end
            default: ram_we = 1'b0;
        endcase
        out_valid  = m_valid_reg;
        out_addr   = m_addr_reg;
        out_status = m_status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == E_DONE && (!m_valid_reg || out_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_clear || (accept && in_op == OP_CLEAR)) begin
                vld_reg <= '0;
            end else if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end
        end
        vq_reg <= vld_reg[ram_raddr];
        if (state_reg == E_DONE && (!m_valid_reg || out_ready)) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
        end
        unique case (state_reg)
            E_IDLE: begin
                align_reg      <= in_align;
                faddr_reg      <= in_faddr;
                res_addr_reg   <= 32'd0;
                res_status_reg <= (in_op == OP_ALLOC && too_big) ? ST_NO_FIT : ST_OK;
                c_reg          <= (in_op == OP_ALLOC) ? req_cls : '0;
            end
            E_A_CLS: begin
                w_reg <= BIT_W'(info.words - WRD_W'(1));
                if (info.words == '0) begin
                    if (last_cls) res_status_reg <= ST_NO_FIT;
                    else c_reg <= c_reg + CLS_W'(1);
                end
            end
            E_A_CHK: begin
                word_reg <= rd_word;
                free_reg <= free_bits;
                a_reg    <= addr_calc;
                j_reg    <= default_al ? low_bit : BIT_W'(WORD_BITS - 1);
                if (full) begin
                    if (!last_word) w_reg <= w_reg - BIT_W'(1);
                    else if (last_cls) res_status_reg <= ST_NO_FIT;
                    else c_reg <= c_reg + CLS_W'(1);
                end
            end
            E_A_BIT: begin
                if (found) begin
                    res_addr_reg <= a_reg;
                end else if (j_reg == '0) begin
                    if (!last_word) w_reg <= w_reg - BIT_W'(1);
                    else if (last_cls) res_status_reg <= ST_NO_FIT;
                    else c_reg <= c_reg + CLS_W'(1);
                end else begin
                    j_reg <= j_reg - BIT_W'(1);
                    a_reg <= a_reg - {23'd0, size9};
                end
            end
            E_A_ADDR: res_addr_reg <= addr_calc;
            E_F_CLS: begin
                if (in_span) begin
                    if (foff[3:0] != 4'd0) res_status_reg <= ST_NOT_SLOT;
                end else if (last_cls) begin
                    res_status_reg <= ST_NOT_SLOT;
                end else begin
                    c_reg <= c_reg + CLS_W'(1);
                end
            end
            E_F_DIV: begin
                idx_reg <= info.first + {2'd0, div_q[9:5]};
                j_reg   <= div_q[4:0];
                if (div_done && div_rem != '0) res_status_reg <= ST_NOT_SLOT;
            end
            E_F_CHK: if (!rd_word[j_reg]) res_status_reg <= ST_NOT_USED;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ tb/tb_size_class_bitmap_allocator_unit.sv @@
`default_nettype none
module tb_size_class_bitmap_allocator_unit;
    import sbma_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [1:0] operation, [10:2] request_size, [14:11] align_log2, [46:15] free_address
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [31:0] result_address, [33:32] status
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    size_class_bitmap_allocator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    typedef struct {
        logic [31:0] addr;
        status_t     status;
    } alloc_reply_t;

    logic [47:0]  request_fifo[$];
    alloc_reply_t reply_fifo[$];
    logic [31:0]  live_blocks[$];

    logic [31:0]  cfg_base;
    logic [6:0]   cfg_blocks;
    logic [31:0]  used_words[MAP_WORDS];
    logic [31:0]  cls_base[NUM_CLASSES];
    int unsigned  cls_count[NUM_CLASSES];
    int unsigned  cls_word0[NUM_CLASSES];
    int unsigned  cls_nwords[NUM_CLASSES];

    int  errors = 0;
    int  replies_seen = 0;
    int  gap_cnt = 0;
    int  stall_cnt = 0;
    int  idle_cycles = 0;
    int  n_ok = 0, n_nofit = 0, n_notslot = 0, n_notused = 0;
    bit  calm = 0;

    function automatic void rebuild_classes();
        longint unsigned off;
        int unsigned first, b, sz, blk, wds;
        off = 0;
        first = 0;
        b = cfg_blocks;
        if (b < 1) b = 1;
        if (b > MAX_B256) b = MAX_B256;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            sz = (c + 1) * 16;
            blk = b * 256 / sz;
            wds = (blk + 31) / 32;
            if (first + wds > MAP_WORDS) begin
                wds = MAP_WORDS - first;
                if (blk > wds * 32) blk = wds * 32;
            end
            off = (off + 31) & ~64'd31;
            cls_base[c] = 32'(cfg_base + off);
            cls_count[c] = blk;
            cls_word0[c] = first;
            cls_nwords[c] = wds;
            off += longint'(sz) * blk + wds * 4;
            first += wds;
        end
        for (int i = 0; i < MAP_WORDS; i++) used_words[i] = '0;
    endfunction

    function automatic status_t predict_allocate(int unsigned req, int unsigned al,
                                                 output logic [31:0] a);
        int unsigned first_cls, sz, left, idx;
        int w, j, pick;
        logic [31:0] valid, fb, cand, amask;
        a = '0;
        if (req > MAX_REQ) return ST_NO_FIT;
        first_cls = (req == 0) ? 0 : (req + 15) / 16 - 1;
        amask = (32'd1 << al) - 1;
        for (int c = first_cls; c < NUM_CLASSES; c++) begin
            sz = (c + 1) * 16;
            for (w = int'(cls_nwords[c]) - 1; w >= 0; w--) begin
                left = cls_count[c] - w * 32;
                valid = (left >= 32) ? '1 : (32'd1 << left) - 1;
                idx = cls_word0[c] + w;
                if (idx >= MAP_WORDS) continue;
                if ((used_words[idx] & valid) == valid) continue;
                fb = ~used_words[idx] & valid;
                pick = -1;
                if (al == DEFAULT_ALIGN) begin
                    for (j = 0; j < 32; j++)
                        if (fb[j]) begin
                            pick = j;
                            break;
                        end
                end else begin
                    for (j = 31; j >= 0; j--)
                        if (fb[j]) begin
                            cand = cls_base[c] + sz * (w * 32 + j);
                            if ((cand & amask) == 0) begin
                                pick = j;
                                break;
                            end
                        end
                end
                if (pick < 0) continue;
                used_words[idx][pick] = 1'b1;
                a = cls_base[c] + sz * (w * 32 + pick);
                return ST_OK;
            end
        end
        return ST_NO_FIT;
    endfunction

    function automatic status_t predict_release(logic [31:0] fa);
        int unsigned sz, slot, idx;
        logic [31:0] off;
        longint unsigned span;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            sz = (c + 1) * 16;
            off = fa - cls_base[c];
            span = longint'(sz) * cls_count[c];
            if (off >= span) continue;
            slot = off / sz;
            if (slot * sz != off) return ST_NOT_SLOT;
            idx = cls_word0[c] + slot / 32;
            if (idx >= MAP_WORDS) return ST_NOT_SLOT;
            if (!used_words[idx][slot % 32]) return ST_NOT_USED;
            used_words[idx][slot % 32] = 1'b0;
            return ST_OK;
        end
        return ST_NOT_SLOT;
    endfunction

    function automatic void predict_request(logic [47:0] d);
        alloc_reply_t r;
        op_t op;
        op = op_t'(d[1:0]);
        r.addr = '0;
        r.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                r.status = predict_allocate(d[10:2], d[14:11], r.addr);
                if (r.status == ST_OK) live_blocks.push_back(r.addr);
            end
            OP_FREE: begin
                r.status = predict_release(d[46:15]);
                if (r.status == ST_OK)
                    foreach (live_blocks[i])
                        if (live_blocks[i] == d[46:15]) begin
                            live_blocks.delete(i);
                            break;
                        end
            end
            OP_CLEAR: begin
                for (int i = 0; i < MAP_WORDS; i++) used_words[i] = '0;
                live_blocks.delete();
            end
            default: ;
        endcase
        reply_fifo.push_back(r);
    endfunction

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_request(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt = gap_cnt - 1;
                    s_tvalid <= 1'b0;
                end else if (request_fifo.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= request_fifo.pop_front();
                    if (!calm && $urandom_range(0, 4) == 0) gap_cnt = $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor
    always @(posedge aclk) begin
        alloc_reply_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (reply_fifo.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, actual addr %h status %0d",
                             $time, m_tdata[31:0], m_tdata[33:32]);
                end else begin
                    e = reply_fifo.pop_front();
                    if (m_tdata[31:0] !== e.addr) begin
                        errors++;
                        $display("%0t: addr mismatch, expected %h actual %h",
                                 $time, e.addr, m_tdata[31:0]);
                    end
                    if (m_tdata[33:32] !== e.status) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, e.status, m_tdata[33:32]);
                    end
                    case (e.status)
                        ST_OK: n_ok++;
                        ST_NO_FIT: n_nofit++;
                        ST_NOT_SLOT: n_notslot++;
                        default: n_notused++;
                    endcase
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt = stall_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) stall_cnt = $urandom_range(1, 4);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("size_class_bitmap_allocator_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic send(op_t op, int unsigned sz, int unsigned al, logic [31:0] fa);
        while (request_fifo.size() >= 2) @(posedge aclk);
        request_fifo.push_back({1'b0, fa, al[3:0], sz[8:0], op});
    endtask

    task automatic drain();
        @(posedge aclk);
        while (request_fifo.size() != 0 || s_tvalid || reply_fifo.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        drain();
        repeat (64) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_BASE) cfg_base = val;
        else cfg_blocks = val[6:0];
        rebuild_classes();
        live_blocks.delete();
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random();
        int r;
        logic [31:0] fa;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send(OP_ALLOC,
                 ($urandom_range(0, 15) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : DEFAULT_ALIGN, $urandom);
        end else if (r < 86 && live_blocks.size() > 0) begin
            send(OP_FREE, $urandom, $urandom, live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
        end else if (r < 94 && live_blocks.size() > 0) begin
            fa = live_blocks[$urandom_range(0, live_blocks.size() - 1)] + $urandom_range(1, 40);
            send(OP_FREE, $urandom, $urandom, fa);
        end else if (r < 97) begin
            send(OP_FREE, $urandom, $urandom, $urandom);
        end else if (r < 98) begin
            send(OP_CLEAR, $urandom, $urandom, $urandom);
        end else begin
            send(OP_NONE, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            send_random();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_BASE;
        cfg_wdata = '0;
        cfg_base = '0;
        cfg_blocks = 7'd16;
        rebuild_classes();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send(OP_ALLOC, 0, DEFAULT_ALIGN, '0);
        send(OP_ALLOC, 1, 0, '1);
        send(OP_ALLOC, 16, 12, '0);
        send(OP_ALLOC, 17, 15, '0);
        send(OP_ALLOC, 256, DEFAULT_ALIGN, '1);
        send(OP_ALLOC, 256, 13, '0);
        send(OP_ALLOC, 257, DEFAULT_ALIGN, '0);
        send(OP_ALLOC, 511, 15, '1);
        drain();
        send(OP_FREE, 0, 0, live_blocks[0]);
        send(OP_FREE, 0, 0, live_blocks[0]);
        send(OP_FREE, 0, 0, live_blocks[1] + 8);
        send(OP_FREE, 0, 0, 32'hFFFF_FFFF);
        send(OP_FREE, 0, 0, '0);
        send(OP_NONE, 511, 15, '1);
        send(OP_CLEAR, 0, 0, '0);
        send(OP_FREE, 0, 0, cls_base[0]);
        random_phase(240);

        write_reg(CFG_BLOCKS, 32'd1);
        random_phase(240);
        write_reg(CFG_BASE, 32'hFFFF_FFE0);
        write_reg(CFG_BLOCKS, 32'd3);
        random_phase(240);
        write_reg(CFG_BASE, $urandom & ~32'd31);
        write_reg(CFG_BLOCKS, 32'd64);
        random_phase(240);
        write_reg(CFG_BLOCKS, 32'd0);
        random_phase(240);
        write_reg(CFG_BLOCKS, {25'($urandom_range(0, 33554431)), 7'd100});
        random_phase(240);
        write_reg(CFG_BASE, 32'h0000_1000);
        write_reg(CFG_BLOCKS, 32'd2);
        calm = 1;
        random_phase(240);

        drain();
        repeat (100) @(posedge aclk);
        $display("Covered %0d replies over 7 layouts incl. wrapped base, block counts 0..100.",
                 replies_seen);
        $display("Status mix: ok %0d, no fit %0d, not a slot %0d, not allocated %0d.",
                 n_ok, n_nofit, n_notslot, n_notused);
        if (errors == 0) begin
            $display("size_class_bitmap_allocator_unit regression: pass");
        end else begin
            $display("size_class_bitmap_allocator_unit regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ size_class_bitmap_allocator_unit.f @@
rtl/sbma_pkg.sv
rtl/sbma_ram.sv
rtl/sbma_div.sv
rtl/sbma_layout.sv
rtl/sbma_engine.sv
rtl/size_class_bitmap_allocator_unit.sv
tb/tb_size_class_bitmap_allocator_unit.sv
